### rtl/core/sfc_pkg.sv
`default_nettype none
package sfc_pkg;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int PLANE_COUNT_DEF = 6;
   localparam int VP_DEPTH        = 16;
   localparam int PC_DEPTH        = 24;
   localparam int VP_AW           = 4;
   localparam int PC_AW           = 5;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_BUILD = 2'd1,
      ACT_TEST  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BRD,
      ST_BCAP,
      ST_BSQ,
      ST_BSUM,
      ST_BSQRT,
      ST_BDIV,
      ST_BWR,
      ST_TRD,
      ST_TMUL,
      ST_TACC,
      ST_TDONE
   } state_type;

   typedef struct packed {
      logic       sqrt_start;
      logic       div_start;
   } unit_ctl_type;

   // Column of the matrix that each plane draws on, and whether column 3 joins it.
   function automatic logic [1:0] plane_col(input logic [2:0] p);
      case (p)
         3'd0, 3'd1: plane_col = 2'd0;
         3'd2, 3'd3: plane_col = 2'd1;
         default:    plane_col = 2'd2;
      endcase
   endfunction

   function automatic logic plane_use3(input logic [2:0] p);
      plane_use3 = (p != 3'd4);
   endfunction

   function automatic logic plane_neg(input logic [2:0] p);
      plane_neg = p[0] && (p != 3'd4);
   endfunction
endpackage
`default_nettype wire

### rtl/core/sfc_ram.sv
`default_nettype none
module sfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/sfc_sqrt.sv
`default_nettype none
module sfc_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [67:0] value,
   output      logic        done,
   output      logic [34:0] root
);
   logic [67:0] rem_ff,  rem_in;
   logic [34:0] root_ff, root_in;
   logic [5:0]  cnt_ff,  cnt_in;
   logic        run_ff,  run_in;
   logic [69:0] trial;
   logic [69:0] remw;

   // Restoring digit-by-digit root, one result bit per cycle.
   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      remw    = '0;
      trial   = '0;
      done    = 1'b0;
      if (start) begin
         rem_in  = value;
         root_in = '0;
         cnt_in  = 6'd34;
         run_in  = 1'b1;
      end else if (run_ff) begin
         remw  = {2'b00, rem_ff};
         trial = ({35'd0, root_ff} << (cnt_ff + 6'd1)) | (70'd1 << {cnt_ff, 1'b0});
         if (trial <= remw) begin
            rem_in  = 68'(remw - trial);
            root_in = root_ff | (35'd1 << cnt_ff);
         end
         if (cnt_ff == 6'd0) begin
            run_in = 1'b0;
            done   = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root = root_in;
endmodule
`default_nettype wire

### rtl/core/sfc_div.sv
`default_nettype none
module sfc_div #(
   parameter int NUM_W = 57
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [34:0]      den,
   output      logic             done,
   output      logic [NUM_W-1:0] quo
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [35:0]      r_ff, r_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic [35:0]      shr;

   // Restoring long division, one quotient bit per cycle.
   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      shr    = '0;
      done   = 1'b0;
      if (start) begin
         q_in   = num;
         r_in   = '0;
         cnt_in = CW'(NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         shr  = {r_ff[34:0], q_ff[NUM_W-1]};
         q_in = {q_ff[NUM_W-2:0], 1'b0};
         if (shr >= {1'b0, den}) begin
            r_in    = shr - {1'b0, den};
            q_in[0] = 1'b1;
         end else begin
            r_in = shr;
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
            done   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   assign quo = q_in;
endmodule
`default_nettype wire

### rtl/core/sphere_frustum_cull.sv
`default_nettype none
// Sphere culling against six frustum planes taken from a view-projection matrix.
// The request channel takes a word when start is high and busy is low. Action
// load writes one matrix element, build derives and normalizes the six planes,
// test checks one sphere. Only a test gives a response: rsp_valid is high for
// exactly one cycle with rsp_inside_res, and the receiver cannot hold it off.
// A test steps, for each plane coefficient, through a read, a multiply and an
// accumulate state, and ends each plane with a compare state; the single read
// port of the plane memory and the shared multiplier set this order. A build
// runs, per plane, eight matrix reads, each a read and a capture state, three
// square-and-add steps, a 35-step square root and four 57-step divisions each
// followed by a write; a plane with a zero normal skips the root and the
// divisions.
// Reset clears the control state and starts a clearing pass over both
// memories, during which busy is high.
// All values are fixed point with FRAC_BITS fraction bits, signed but for the radius.
module sphere_frustum_cull
   import sfc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [3:0]  req_matrix_index,
   input  wire logic signed [31:0] req_matrix_value,
   input  wire logic signed [31:0] req_center_x,
   input  wire logic signed [31:0] req_center_y,
   input  wire logic signed [31:0] req_center_z,
   input  wire logic [30:0] req_radius,
   output      logic        rsp_valid,
   output      logic        rsp_inside_res
);
   localparam int NUM_W = 33 + FRAC_BITS + 8;

   state_type   st_ff, st_in;
   logic [4:0]  clr_ff, clr_in;
   logic        clr_run_ff, clr_run_in;
   logic [2:0]  pl_ff, pl_in;
   logic [2:0]  k_ff, k_in;
   logic signed [32:0] raw_ff [4];
   logic signed [32:0] raw_in [4];
   logic [67:0] sum_ff, sum_in;
   logic [65:0] sq_ff, sq_in;
   logic [34:0] len_ff, len_in;
   logic [31:0] wq_ff, wq_in;
   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0] r_ff;
   logic signed [127:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic        cull_ff, cull_in;
   logic        rv_ff, rv_in, ri_ff, ri_in;
   logic        cap_ok;

   logic        vp_we, pc_we;
   logic [VP_AW-1:0] vp_wa, vp_ra;
   logic [PC_AW-1:0] pc_wa, pc_ra;
   logic [31:0] vp_wd, vp_rd, pc_wd, pc_rd;

   unit_ctl_type uc;
   logic        sq_done, dv_done;
   logic [34:0] sq_root;
   logic [NUM_W-1:0] dv_num, dv_quo;
   logic [32:0] mag;
   logic [1:0]  dv_k;
   logic        accept;
   logic [1:0]  rcol;
   logic [1:0]  rrow;

   sfc_ram #(.WIDTH(32), .DEPTH(VP_DEPTH)) u_vp (
      .clock(clock), .wr_en(vp_we), .wr_addr(vp_wa), .wr_data(vp_wd),
      .rd_addr(vp_ra), .rd_data(vp_rd));
   sfc_ram #(.WIDTH(32), .DEPTH(PC_DEPTH)) u_pc (
      .clock(clock), .wr_en(pc_we), .wr_addr(pc_wa), .wr_data(pc_wd),
      .rd_addr(pc_ra), .rd_data(pc_rd));

   sfc_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(uc.sqrt_start), .value(sum_in),
      .done(sq_done), .root(sq_root));

   sfc_div #(.NUM_W(NUM_W)) u_div (
      .clock(clock), .reset(reset), .start(uc.div_start), .num(dv_num), .den(len_ff),
      .done(dv_done), .quo(dv_quo));

   assign busy   = (st_ff != ST_IDLE) || clr_run_ff;
   assign accept = start && !busy;

   // A division started from the write state works on the next coefficient.
   always_comb begin
      dv_k = (st_ff == ST_BWR) ? k_ff[1:0] + 2'd1 : k_ff[1:0];
      mag = raw_ff[dv_k][32] ? 33'(-raw_ff[dv_k]) : 33'(raw_ff[dv_k]);
      dv_num = NUM_W'({mag, FRAC_BITS'(0)});
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept && req_action == ACT_BUILD) begin
               st_in = ST_BRD;
            end else if (accept && req_action == ACT_TEST) begin
               st_in = ST_TRD;
            end
         end
         ST_BRD:   st_in = ST_BCAP;
         ST_BCAP:  st_in = cap_ok ? ST_BSQ : ST_BRD;
         ST_BSQ:   st_in = ST_BSUM;
         ST_BSUM:  st_in = (k_ff == 3'd2) ? ST_BSQRT : ST_BSQ;
         ST_BSQRT: st_in = (sum_ff == '0) ? ST_BWR : (sq_done ? ST_BDIV : ST_BSQRT);
         ST_BDIV:  st_in = dv_done ? ST_BWR : ST_BDIV;
         ST_BWR: begin
            if (k_ff == 3'd3) begin
               st_in = (pl_ff == 3'd5) ? ST_IDLE : ST_BRD;
            end else begin
               st_in = (sum_ff == '0) ? ST_BWR : ST_BDIV;
            end
         end
         ST_TRD:   st_in = ST_TMUL;
         ST_TMUL:  st_in = ST_TACC;
         ST_TACC:  st_in = (k_ff == 3'd3) ? ST_TDONE : ST_TRD;
         ST_TDONE: st_in = (pl_ff == 3'd5) ? ST_IDLE : ST_TRD;
         default:  st_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      pl_in   = pl_ff;
      k_in    = k_ff;
      raw_in  = raw_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      len_in  = len_ff;
      wq_in   = wq_ff;
      acc_in  = acc_ff;
      prod_in = prod_ff;
      cull_in = cull_ff;
      rv_in   = 1'b0;
      ri_in   = ri_ff;
      clr_in  = clr_ff;
      clr_run_in = clr_run_ff;
      uc      = '0;
      cap_ok  = 1'b0;
      vp_we   = 1'b0;
      vp_wa   = req_matrix_index;
      vp_wd   = req_matrix_value;
      pc_we   = 1'b0;
      pc_wa   = PC_AW'({pl_ff, k_ff[1:0]});
      pc_wd   = wq_ff;
      rcol    = k_ff[0] ? plane_col(pl_ff) : 2'd3;
      rrow    = k_ff[2:1];
      vp_ra   = {rrow, rcol};
      pc_ra   = PC_AW'({pl_ff, k_ff[1:0]});
      if (clr_run_ff) begin
         vp_we = 1'b1;
         vp_wa = clr_ff[VP_AW-1:0];
         vp_wd = '0;
         pc_we = 1'b1;
         pc_wa = clr_ff;
         pc_wd = '0;
         clr_in = clr_ff + 5'd1;
         if (clr_ff == 5'(PC_DEPTH - 1)) begin
            clr_run_in = 1'b0;
         end
      end
      case (st_ff)
         ST_IDLE: begin
            pl_in   = '0;
            k_in    = '0;
            acc_in  = '0;
            cull_in = 1'b0;
            if (accept && req_action == ACT_LOAD) begin
               vp_we = 1'b1;
            end
            if (accept && req_action == ACT_BUILD) begin
               raw_in = '{default: '0};
            end
         end
         ST_BRD: begin
         end
         ST_BCAP: begin
            // k walks row-by-row: even k reads column 3, odd k the plane's column.
            if (!k_ff[0]) begin
               raw_in[k_ff[2:1]] = plane_use3(pl_ff) ? 33'(signed'(vp_rd)) : '0;
            end else begin
               raw_in[k_ff[2:1]] = plane_neg(pl_ff)
                  ? 33'(raw_ff[k_ff[2:1]] - 33'(signed'(vp_rd)))
                  : 33'(raw_ff[k_ff[2:1]] + 33'(signed'(vp_rd)));
            end
            if (k_ff == 3'd7) begin
               cap_ok = 1'b1;
               k_in   = '0;
               sum_in = '0;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_BSQ: begin
            sq_in = 66'(mag) * 66'(mag);
         end
         ST_BSUM: begin
            sum_in = sum_ff + 68'(sq_ff);
            if (k_ff == 3'd2) begin
               k_in = '0;
               uc.sqrt_start = (sum_ff + 68'(sq_ff)) != '0;
            end else begin
               k_in = k_ff + 3'd1;
            end
         end
         ST_BSQRT: begin
            if (sum_ff == '0) begin
               wq_in = (raw_ff[0] > 33'sd2147483647) ? 32'h7FFFFFFF :
                       (raw_ff[0] < -33'sd2147483648) ? 32'h80000000 : 32'(raw_ff[0]);
            end else if (sq_done) begin
               len_in = sq_root;
               uc.div_start = 1'b1;
            end
         end
         ST_BDIV: begin
            if (dv_done) begin
               if (dv_quo >= NUM_W'(33'h080000000)) begin
                  wq_in = raw_ff[k_ff[1:0]][32] ? 32'h80000000 : 32'h7FFFFFFF;
               end else begin
                  wq_in = raw_ff[k_ff[1:0]][32] ? 32'(-dv_quo[31:0]) : dv_quo[31:0];
               end
            end
         end
         ST_BWR: begin
            pc_we = 1'b1;
            if (k_ff == 3'd3) begin
               k_in  = '0;
               pl_in = pl_ff + 3'd1;
               raw_in = '{default: '0};
            end else begin
               k_in = k_ff + 3'd1;
               if (sum_ff == '0) begin
                  wq_in = (raw_ff[k_ff[1:0] + 2'd1] > 33'sd2147483647) ? 32'h7FFFFFFF :
                          (raw_ff[k_ff[1:0] + 2'd1] < -33'sd2147483648) ? 32'h80000000 :
                          32'(raw_ff[k_ff[1:0] + 2'd1]);
               end else begin
                  uc.div_start = 1'b1;
               end
            end
         end
         ST_TRD: begin
         end
         ST_TMUL: begin
            case (k_ff[1:0])
               2'd0:    prod_in = 64'(cx_ff) * 64'(signed'(pc_rd));
               2'd1:    prod_in = 64'(cy_ff) * 64'(signed'(pc_rd));
               2'd2:    prod_in = 64'(cz_ff) * 64'(signed'(pc_rd));
               default: prod_in = 64'(signed'(pc_rd)) <<< FRAC_BITS;
            endcase
         end
         ST_TACC: begin
            acc_in = acc_ff + 128'(prod_ff);
            k_in   = k_ff + 3'd1;
         end
         ST_TDONE: begin
            if (acc_ff + 128'(signed'({1'b0, r_ff, FRAC_BITS'(0)})) <= 128'sd0) begin
               cull_in = 1'b1;
            end
            acc_in = '0;
            k_in   = '0;
            pl_in  = pl_ff + 3'd1;
            if (pl_ff == 3'd5) begin
               rv_in = 1'b1;
               ri_in = !(cull_in);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         clr_ff     <= '0;
         clr_run_ff <= 1'b1;
         rv_ff      <= 1'b0;
      end else begin
         st_ff      <= st_in;
         clr_ff     <= clr_in;
         clr_run_ff <= clr_run_in;
         rv_ff      <= rv_in;
      end
      pl_ff   <= pl_in;
      k_ff    <= k_in;
      raw_ff  <= raw_in;
      sum_ff  <= sum_in;
      sq_ff   <= sq_in;
      len_ff  <= len_in;
      wq_ff   <= wq_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      cull_ff <= cull_in;
      ri_ff   <= ri_in;
      if (accept) begin
         cx_ff <= req_center_x;
         cy_ff <= req_center_y;
         cz_ff <= req_center_z;
         r_ff  <= req_radius;
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_inside_res = ri_ff;
endmodule
`default_nettype wire

### rtl/core/sfc_checker.sv
`default_nettype none
module sfc_props
   import sfc_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic [1:0] req_action
);
   a_no_double_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("two responses back to back");
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy) else $error("idle during clearing pass");
   a_test_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_TEST) |=> busy) else $error("test not taken");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid) else $error("response without a test");
endmodule

bind sphere_frustum_cull sfc_props u_sfc_props (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .req_action(req_action));
`default_nettype wire

### verif/sfc_checker.sv
`timescale 1ns / 100ps
module sfc_checker
   import sfc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [1:0]         req_action,
   input  wire logic [3:0]         req_matrix_index,
   input  wire logic signed [31:0] req_matrix_value,
   input  wire logic signed [31:0] req_center_x,
   input  wire logic signed [31:0] req_center_y,
   input  wire logic signed [31:0] req_center_z,
   input  wire logic [30:0]        req_radius,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_inside_res,
   output int                      errors,
   output int                      pending
);
   logic signed [31:0] view_proj [VP_DEPTH];
   logic signed [31:0] planes [PC_DEPTH];
   logic inside_fifo [$];

   assign pending = inside_fifo.size();

   task automatic report_mismatch(input string what);
      $display("sfc_checker: mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] magnitude(input longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] root_floor(input logic [127:0] s);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (128'(t) * 128'(t) <= s) r = t;
      end
      return r;
   endfunction

   task automatic derive_planes();
      longint raw [4];
      logic [127:0] norm_sq;
      logic [63:0] len, q;
      logic [1:0] col;
      longint v;
      for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
         col = (p < 2) ? 2'd0 : (p < 4) ? 2'd1 : 2'd2;
         norm_sq = '0;
         for (int k = 0; k < 4; k++) begin
            raw[k] = longint'(view_proj[k*4 + col]);
            if (p % 2 == 1 && p != 4) raw[k] = -raw[k];
            if (p != 4) raw[k] += longint'(view_proj[k*4 + 3]);
            if (k < 3) norm_sq += 128'(magnitude(raw[k])) * 128'(magnitude(raw[k]));
         end
         if (norm_sq == 0) begin
            for (int k = 0; k < 4; k++) planes[p*4 + k] = clamp32(raw[k]);
         end else begin
            len = root_floor(norm_sq);
            for (int k = 0; k < 4; k++) begin
               q = (magnitude(raw[k]) << FRAC_BITS_DEF) / len;
               if (q > 64'h80000000) q = 64'h80000000;
               v = raw[k] < 0 ? -longint'(q) : longint'(q);
               planes[p*4 + k] = clamp32(v);
            end
         end
      end
   endtask

   function automatic logic sphere_visible(input logic signed [31:0] cx,
                                           input logic signed [31:0] cy,
                                           input logic signed [31:0] cz,
                                           input logic [30:0] rad);
      logic signed [127:0] acc, x, y, z, r, n0, n1, n2, d;
      x = cx;
      y = cy;
      z = cz;
      r = $signed({97'd0, rad});
      for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
         n0 = planes[p*4];
         n1 = planes[p*4 + 1];
         n2 = planes[p*4 + 2];
         d = planes[p*4 + 3];
         acc = x*n0 + y*n1 + z*n2 + ((d + r) <<< FRAC_BITS_DEF);
         if (acc <= 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         errors = 0;
         inside_fifo.delete();
         for (int i = 0; i < VP_DEPTH; i++) view_proj[i] = '0;
         for (int i = 0; i < PC_DEPTH; i++) planes[i] = '0;
      end else begin
         if (rsp_valid) begin
            if (inside_fifo.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else if (inside_fifo[0] !== rsp_inside_res) begin
               report_mismatch($sformatf("inside_res got %b expected %b",
                                         rsp_inside_res, inside_fifo[0]));
               void'(inside_fifo.pop_front());
            end else begin
               void'(inside_fifo.pop_front());
            end
         end
         if (start && !busy) begin
            case (action_type'(req_action))
               ACT_LOAD:  view_proj[req_matrix_index] = req_matrix_value;
               ACT_BUILD: derive_planes();
               ACT_TEST:  inside_fifo.push_back(sphere_visible(req_center_x,
                             req_center_y, req_center_z, req_radius));
               default: ;
            endcase
         end
      end
   end
endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import sfc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = ACT_NONE;
   logic [3:0] req_matrix_index = '0;
   logic signed [31:0] req_matrix_value = '0;
   logic signed [31:0] req_center_x = '0;
   logic signed [31:0] req_center_y = '0;
   logic signed [31:0] req_center_z = '0;
   logic [30:0] req_radius = '0;
   logic rsp_valid;
   logic rsp_inside_res;
   int errors;
   int pending;
   int sent;

   always #5 clock = ~clock;

   sphere_frustum_cull DUT (.*);

   sfc_checker u_checker (.*);

   task automatic send_word(input action_type act, input logic [3:0] idx,
                            input logic signed [31:0] val, input logic signed [31:0] cx,
                            input logic signed [31:0] cy, input logic signed [31:0] cz,
                            input logic [30:0] rad);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_action <= act;
      req_matrix_index <= idx;
      req_matrix_value <= val;
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_radius <= rad;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic load_elem(input logic [3:0] idx, input logic signed [31:0] val);
      send_word(ACT_LOAD, idx, val, $urandom, $urandom, $urandom, 31'($urandom));
   endtask

   task automatic test_sphere(input logic signed [31:0] cx, input logic signed [31:0] cy,
                              input logic signed [31:0] cz, input logic [30:0] rad);
      send_word(ACT_TEST, 4'($urandom), $urandom, cx, cy, cz, rad);
   endtask

   function automatic logic signed [31:0] near_value(input int span);
      return $signed($urandom_range(0, 2*span)) - span;
   endfunction

   initial begin
      int n;
      sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Spheres against the all-zero planes left by reset.
      test_sphere(0, 0, 0, 0);
      test_sphere(32'h7fffffff, 32'h80000000, 0, 31'h7fffffff);
      send_word(ACT_NONE, 4'hf, 32'h80000000, 32'h7fffffff, 0, 0, 31'h7fffffff);
      // Zero normal on every plane.
      send_word(ACT_BUILD, 0, 0, 0, 0, 0, 0);
      test_sphere(0, 0, 0, 1);
      // Saturating extremes in the matrix.
      load_elem(0, 32'h80000000);
      load_elem(3, 32'h7fffffff);
      load_elem(15, 32'h80000000);
      load_elem(6, 32'h7fffffff);
      load_elem(9, 32'h00010000);
      send_word(ACT_BUILD, 0, 0, 0, 0, 0, 0);
      test_sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
      test_sphere(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
      test_sphere(0, 0, 0, 0);
      test_sphere(32'h00010000, 0, 32'hffff0000, 31'h00008000);

      n = 0;
      while (sent < 1650) begin
         if ($urandom_range(0, 9) < 8) begin
            for (int i = 0; i < 16; i++) begin
               if ($urandom_range(0, 3) == 0) load_elem(4'(i), 0);
               else if ($urandom_range(0, 15) == 0) load_elem(4'(i), $urandom);
               else load_elem(4'(i), near_value(1 << 17));
            end
            send_word(ACT_BUILD, 4'($urandom), $urandom, $urandom, $urandom, $urandom,
                      31'($urandom));
            repeat ($urandom_range(5, 40)) begin
               if ($urandom_range(0, 9) == 0)
                  test_sphere($urandom, $urandom, $urandom, 31'($urandom));
               else
                  test_sphere(near_value(1 << 20), near_value(1 << 20), near_value(1 << 20),
                              31'($urandom_range(0, 1 << 18)));
            end
            n++;
            if (n == 3) begin
               @(negedge clock);
               start <= 1'b0;
               wait (pending == 0);
            end
         end else begin
            repeat ($urandom_range(1, 6))
               send_word(action_type'($urandom_range(0, 3)), 4'($urandom), $urandom,
                         $urandom, $urandom, $urandom, 31'($urandom));
         end
      end
      @(negedge clock);
      start <= 1'b0;
      wait (pending == 0);
      repeat (2000) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
